>>> sv/dsc_pkg.sv
// Shared types and constants for the delta-modulation sample channel.
// Used by dsc_regs, dsc_core and delta_sample_channel; depends on nothing.
package dsc_pkg;

	// Request kinds carried in req_type
	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_START = 2'd1;
	localparam logic [1:0] REQ_STOP  = 2'd2;
	localparam logic [1:0] REQ_BYTE  = 2'd3;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_IRQ_EN   = 3'd4;

	localparam int unsigned CFG_DATA_W = 10;

	localparam logic [9:0]  PERIOD_RESET = 10'd428;
	localparam logic [14:0] ADDR_BASE    = 15'h4000;
	localparam logic [11:0] BYTES_MAX    = 12'd4081;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] fetched_byte;
	} in_word_t;

	typedef struct packed {
		logic [6:0]  level_out;
		logic        fetch_request;
		logic [14:0] fetch_address;
		logic        interrupt_flag;
		logic [11:0] bytes_pending;
	} out_word_t;

	typedef struct packed {
		logic [9:0] period_reload;
		logic [7:0] start_offset;
		logic [7:0] length_setting;
		logic       loop_enable;
		logic       interrupt_enable;
	} cfg_t;

endpackage

>>> sv/dsc_regs.sv
// Configuration register file for the delta-modulation sample channel.
// Depends on dsc_pkg for register indexes and the cfg_t bundle.
module dsc_regs import dsc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// Write one register per accepted word; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.period_reload    <= PERIOD_RESET;
			cfg_q.start_offset     <= '0;
			cfg_q.length_setting   <= '0;
			cfg_q.loop_enable      <= 1'b0;
			cfg_q.interrupt_enable <= 1'b0;
		end else if (wr_en) begin
			case (wr_index)
				REG_PERIOD: cfg_q.period_reload    <= wr_data[9:0];
				REG_START:  cfg_q.start_offset     <= wr_data[7:0];
				REG_LENGTH: cfg_q.length_setting   <= wr_data[7:0];
				REG_LOOP:   cfg_q.loop_enable      <= wr_data[0];
				REG_IRQ_EN: cfg_q.interrupt_enable <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> sv/dsc_core.sv
// Channel state and single-pass update logic for one request word.
// Depends on dsc_pkg for request codes, constants and word types.
module dsc_core import dsc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  in_word_t  item,
	input  cfg_t      cfg,
	output out_word_t result
);

	logic [6:0]  level_q;
	logic [7:0]  shift_q;
	logic [2:0]  bit_idx_q;
	logic        shift_vld_q;
	logic [9:0]  period_q;
	logic [11:0] bytes_q;
	logic [14:0] addr_q;
	logic [7:0]  buf_q;
	logic        buf_full_q;
	logic        irq_q;

	logic [6:0]  level_n;
	logic [7:0]  shift_n;
	logic [2:0]  bit_idx_n;
	logic        shift_vld_n;
	logic [9:0]  period_n;
	logic [11:0] bytes_n;
	logic [14:0] addr_n;
	logic [7:0]  buf_n;
	logic        buf_full_n;
	logic        irq_n;
	logic        req_n;

	logic [9:0]  period_dec;
	logic [14:0] start_addr;
	logic [11:0] start_len;

	assign period_dec = period_q - 10'd1;
	assign start_addr = ADDR_BASE + {1'b0, cfg.start_offset, 6'b0};
	assign start_len  = {cfg.length_setting, 4'b0} + 12'd1;

	// Compute next state and the fetch request for the current word
	always_comb begin
		level_n     = level_q;
		shift_n     = shift_q;
		bit_idx_n   = bit_idx_q;
		shift_vld_n = shift_vld_q;
		period_n    = period_q;
		bytes_n     = bytes_q;
		addr_n      = addr_q;
		buf_n       = buf_q;
		buf_full_n  = buf_full_q;
		irq_n       = irq_q;
		req_n       = 1'b0;
		case (item.req_type)
			REQ_TICK: begin
				period_n = period_dec;
				if (period_dec == 10'd0) begin
					// Move the level by the current sample bit, clamped to range
					if (shift_vld_q) begin
						if (shift_q[bit_idx_q]) begin
							if (level_q <= 7'd125)
								level_n = level_q + 7'd2;
						end else begin
							if (level_q >= 7'd2)
								level_n = level_q - 7'd2;
						end
					end
					bit_idx_n = bit_idx_q + 3'd1;
					// End of byte: pull the buffered byte into the shifter
					if (bit_idx_q == 3'd7) begin
						if (buf_full_q) begin
							shift_vld_n = 1'b1;
							shift_n     = buf_q;
							buf_full_n  = 1'b0;
							req_n       = (bytes_q != 12'd0);
						end else begin
							shift_vld_n = 1'b0;
						end
					end
					period_n = cfg.period_reload;
				end
			end
			REQ_START: begin
				if (bytes_q == 12'd0) begin
					addr_n  = start_addr;
					bytes_n = start_len;
					req_n   = !buf_full_q;
				end
			end
			REQ_STOP: begin
				bytes_n = 12'd0;
			end
			REQ_BYTE: begin
				if (bytes_q != 12'd0) begin
					buf_n      = item.fetched_byte;
					buf_full_n = 1'b1;
					bytes_n    = bytes_q - 12'd1;
					addr_n     = addr_q + 15'd1;
					// Last byte: restart the sample or flag the end
					if (bytes_q == 12'd1) begin
						if (cfg.loop_enable) begin
							addr_n  = start_addr;
							bytes_n = start_len;
						end else if (cfg.interrupt_enable) begin
							irq_n = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
	end

	// Advance state when a word is processed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q     <= '0;
			shift_q     <= '0;
			bit_idx_q   <= '0;
			shift_vld_q <= 1'b0;
			period_q    <= PERIOD_RESET;
			bytes_q     <= '0;
			addr_q      <= '0;
			buf_q       <= '0;
			buf_full_q  <= 1'b0;
			irq_q       <= 1'b0;
		end else if (step) begin
			level_q     <= level_n;
			shift_q     <= shift_n;
			bit_idx_q   <= bit_idx_n;
			shift_vld_q <= shift_vld_n;
			period_q    <= period_n;
			bytes_q     <= bytes_n;
			addr_q      <= addr_n;
			buf_q       <= buf_n;
			buf_full_q  <= buf_full_n;
			irq_q       <= irq_n;
		end
	end

	assign result.level_out      = level_q;
	assign result.fetch_request  = req_n;
	assign result.fetch_address  = addr_n;
	assign result.interrupt_flag = irq_n;
	assign result.bytes_pending  = bytes_n;

`ifndef SYNTH
	a_irq_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		irq_q |=> irq_q)
		else $error("interrupt flag cleared");
	a_bytes_range: assert property (@(posedge clk) disable iff (!arst_n)
		bytes_q <= BYTES_MAX)
		else $error("byte count out of range");
	a_level_step: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> (level_q == $past(level_q)) || (level_q == $past(level_q) + 7'd2)
			|| (level_q + 7'd2 == $past(level_q)))
		else $error("level moved by more than one step");
	a_tick_req: assert property (@(posedge clk) disable iff (!arst_n)
		step && (item.req_type == REQ_TICK) && req_n |-> buf_full_q)
		else $error("tick fetch request without buffered byte");
`endif

endmodule

>>> sv/delta_sample_channel.sv
// Delta-modulation sample channel: one request word in, one result word out.
// Request words pass the input register, the update logic and the result register
// in order. Throughput: one word per cycle while rsp_ready allows, bound by the
// state update in dsc_core; a stalled result holds one word.
// Reset (arst_n, async, active low) clears the valid flags and the channel and
// config state; period count and period_reload return to 428, the rest to zero.
module delta_sample_channel import dsc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  in_word_t              req,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output out_word_t             rsp,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	in_word_t  req_s1;
	logic      vld_s1;
	out_word_t rsp_s2;
	logic      vld_s2;
	out_word_t result;
	cfg_t      cfg;
	logic      advance;
	logic      step;

	assign cfg_ready = 1'b1;
	assign advance   = !vld_s2 || rsp_ready;
	assign req_ready = !vld_s1 || advance;
	assign step      = vld_s1 && advance;

	dsc_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	dsc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (req_s1),
		.cfg    (cfg),
		.result (result)
	);

	// Capture the incoming word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req_ready) begin
			vld_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid)
			req_s1 <= req;
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step)
			rsp_s2 <= result;
	end

	assign rsp_valid = vld_s2;
	assign rsp       = rsp_s2;

`ifndef SYNTH
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !advance |=> vld_s1 && $stable(req_s1))
		else $error("input stage lost a word under stall");
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && !rsp_ready |=> vld_s2 && $stable(rsp_s2))
		else $error("result changed under stall");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> vld_s2)
		else $error("processed word did not reach the result register");
`endif

endmodule

>>> bench/testbench.sv
// Self-checking bench for delta_sample_channel: playback traffic, register phases, idle mixes.
// Predicts every result word in-line and compares it field by field; needs dsc_pkg and the RTL.
module testbench;
	import dsc_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int unsigned QUIET_LIMIT = 5000;

	typedef enum int unsigned {BYTES_RANDOM, BYTES_ONES, BYTES_ZEROS} byte_mix_e;

	// Channel state as the bench tracks it
	typedef struct packed {
		logic [6:0]  level;
		logic [7:0]  sample;
		logic [2:0]  bit_pos;
		logic        sample_live;
		logic [9:0]  countdown;
		logic [11:0] bytes_left;
		logic [14:0] address;
		logic [7:0]  buffer;
		logic        buffer_full;
		logic        irq;
	} chan_state_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_ready;
	in_word_t              req = '0;
	logic                  rsp_valid;
	logic                  rsp_ready = 1'b0;
	out_word_t             rsp;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	chan_state_t chan;
	cfg_t        shadow_regs;
	int unsigned bit_periods = 0;
	out_word_t   last_prediction;
	out_word_t   channel_outputs_due[$];
	int unsigned mismatches = 0;
	int unsigned send_idle_pct = 0;
	int unsigned rsp_stall_pct = 0;
	bit          word_offered = 1'b0;

	delta_sample_channel dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Load address and count when nothing is pending; ask for a byte if the buffer is empty
	function automatic logic reload_sample();
		if (chan.bytes_left == '0) begin
			chan.address    = ADDR_BASE + {shadow_regs.start_offset, 6'd0};
			chan.bytes_left = {shadow_regs.length_setting, 4'd0} + 12'd1;
			return !chan.buffer_full;
		end
		return 1'b0;
	endfunction

	// Advance the tracked channel by one request word and return the result word it yields
	function automatic out_word_t next_channel_output(input in_word_t word);
		out_word_t result;
		logic      fetch;
		fetch = 1'b0;
		result.level_out = chan.level;
		case (word.req_type)
			REQ_TICK: begin
				chan.countdown = chan.countdown - 10'd1;
				if (chan.countdown == '0) begin
					bit_periods++;
					// Step the level by the current bit, clamped to 0..126
					if (chan.sample_live) begin
						if (chan.sample[chan.bit_pos]) begin
							if (chan.level <= 7'd125)
								chan.level = chan.level + 7'd2;
						end else if (chan.level >= 7'd2) begin
							chan.level = chan.level - 7'd2;
						end
					end
					chan.bit_pos = chan.bit_pos + 3'd1;
					// Swap in the buffered byte after the eighth bit
					if (chan.bit_pos == '0) begin
						if (chan.buffer_full) begin
							chan.sample_live = 1'b1;
							chan.sample      = chan.buffer;
							chan.buffer_full = 1'b0;
							fetch            = (chan.bytes_left != '0);
						end else begin
							chan.sample_live = 1'b0;
						end
					end
					chan.countdown = shadow_regs.period_reload;
				end
			end
			REQ_START: begin
				fetch = reload_sample();
			end
			REQ_STOP: begin
				chan.bytes_left = '0;
			end
			REQ_BYTE: begin
				// Drop a byte that nobody asked for
				if (chan.bytes_left != '0) begin
					chan.buffer      = word.fetched_byte;
					chan.buffer_full = 1'b1;
					chan.bytes_left  = chan.bytes_left - 12'd1;
					chan.address     = chan.address + 15'd1;
					if (chan.bytes_left == '0) begin
						if (shadow_regs.loop_enable)
							fetch = reload_sample();
						else if (shadow_regs.interrupt_enable)
							chan.irq = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		result.fetch_request  = fetch;
		result.fetch_address  = chan.address;
		result.interrupt_flag = chan.irq;
		result.bytes_pending  = chan.bytes_left;
		return result;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
		input int unsigned want);
		$display("MISMATCH %0s: got %0d, expected %0d (t=%0t)", what, got, want, $time);
		mismatches++;
	endtask

	// Offer one request word, wait for it to be taken, then record its expected result
	task automatic send_word(input logic [1:0] kind, input logic [7:0] data);
		in_word_t word;
		word.req_type     = kind;
		word.fetched_byte = data;
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			if (word_offered)
				req_valid <= 1'b0;
			word_offered = 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req_valid    <= 1'b1;
		req          <= word;
		word_offered = 1'b1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		last_prediction = next_channel_output(word);
		channel_outputs_due.push_back(last_prediction);
	endtask

	// Hold off the sender until every outstanding result word has come back
	task automatic drain_outputs();
		if (word_offered)
			req_valid <= 1'b0;
		word_offered = 1'b0;
		while (channel_outputs_due.size() != 0) @(posedge clk);
	endtask

	// Write one register; valid stays up so back-to-back writes need no gap
	task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
		input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (index)
			REG_PERIOD: shadow_regs.period_reload    = data;
			REG_START:  shadow_regs.start_offset     = data[7:0];
			REG_LENGTH: shadow_regs.length_setting   = data[7:0];
			REG_LOOP:   shadow_regs.loop_enable      = data[0];
			REG_IRQ_EN: shadow_regs.interrupt_enable = data[0];
			default: begin
			end
		endcase
	endtask

	task automatic end_config();
		cfg_valid <= 1'b0;
	endtask

	// Write all five registers, with junk above each register's width but the period's
	task automatic set_config(input logic [9:0] period, input logic [7:0] offset,
		input logic [7:0] length, input logic loop_on, input logic irq_on);
		logic [CFG_DATA_W-1:0] junk;
		write_reg(REG_PERIOD, period);
		junk = 10'($urandom());
		write_reg(REG_START, {junk[9:8], offset});
		junk = 10'($urandom());
		write_reg(REG_LENGTH, {junk[9:8], length});
		junk = 10'($urandom());
		write_reg(REG_LOOP, {junk[9:1], loop_on});
		junk = 10'($urandom());
		write_reg(REG_IRQ_EN, {junk[9:1], irq_on});
		end_config();
	endtask

	// Send ticks until one output bit period has elapsed
	task automatic tick_until_bit();
		int unsigned seen;
		seen = bit_periods;
		while (bit_periods == seen)
			send_word(REQ_TICK, 8'($urandom()));
	endtask

	// Drive playback like the memory side would: answer each fetch a few ticks later,
	// start a new sample when idle, and sprinkle in stray words
	task automatic play_sample(input int unsigned count, input byte_mix_e mix,
		input int unsigned noise_pct, input bit hold_midway);
		int unsigned owed;
		int unsigned wait_ticks;
		int unsigned pick;
		logic [1:0]  kind;
		logic [7:0]  data;
		owed       = 0;
		wait_ticks = 0;
		for (int unsigned i = 0; i < count; i++) begin
			if (hold_midway && i == count / 2)
				drain_outputs();
			pick = $urandom_range(99);
			data = 8'($urandom());
			if (owed != 0 && wait_ticks == 0) begin
				kind = REQ_BYTE;
				case (mix)
					BYTES_ONES:  data = 8'hFF;
					BYTES_ZEROS: data = 8'h00;
					default:     data = 8'($urandom());
				endcase
				owed--;
				if (owed != 0)
					wait_ticks = $urandom_range(5);
			end else if (pick < noise_pct) begin
				kind = 2'($urandom_range(REQ_BYTE, REQ_TICK));
			end else if (chan.bytes_left == '0 && owed == 0 && (pick < 10 || noise_pct == 0)) begin
				kind = REQ_START;
			end else begin
				kind = REQ_TICK;
				if (wait_ticks != 0)
					wait_ticks--;
			end
			send_word(kind, data);
			if (last_prediction.fetch_request) begin
				if (owed == 0)
					wait_ticks = $urandom_range(5);
				owed++;
			end
		end
	endtask

	// Reset defaults, stray byte, start twice, then flush the reset-time period
	task automatic test_reset_defaults();
		send_word(REQ_STOP, 8'h00);
		send_word(REQ_BYTE, 8'h5A);
		send_word(REQ_START, 8'hFF);
		send_word(REQ_START, 8'h00);
		send_word(REQ_BYTE, 8'hFF);
		send_word(REQ_TICK, 8'hA5);
		drain_outputs();
		write_reg(REG_PERIOD, 10'd1);
		write_reg(REG_UNUSED, 10'($urandom()));
		end_config();
		repeat (4) tick_until_bit();
	endtask

	// Saturate the level at the top with all-ones bytes, then at zero
	task automatic test_level_limits();
		drain_outputs();
		set_config(10'd1, 8'($urandom_range(255)), 8'd0, 1'b1, 1'b0);
		send_word(REQ_STOP, 8'($urandom()));
		play_sample(90, BYTES_ONES, 0, 1'b0);
		play_sample(90, BYTES_ZEROS, 0, 1'b0);
	endtask

	// Stop mid-sample: the buffered byte and the current sample still play out
	task automatic test_stop_playout();
		drain_outputs();
		set_config(10'd2, 8'h00, 8'd1, 1'b0, 1'b0);
		send_word(REQ_STOP, 8'($urandom()));
		send_word(REQ_START, 8'($urandom()));
		send_word(REQ_BYTE, 8'h0F);
		send_word(REQ_BYTE, 8'hF0);
		send_word(REQ_STOP, 8'($urandom()));
		send_word(REQ_BYTE, 8'h33);
		repeat (8) tick_until_bit();
	endtask

	// Random playback under each idle mix, with fresh registers per phase
	task automatic test_random_traffic();
		int unsigned send_mix[4];
		int unsigned stall_mix[4];
		logic [7:0]  length;
		send_mix  = '{0, 84, 0, 17};
		stall_mix = '{0, 0, 84, 17};
		for (int p = 0; p < 4; p++) begin
			drain_outputs();
			send_idle_pct = send_mix[p];
			rsp_stall_pct = stall_mix[p];
			length = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(3));
			set_config(10'($urandom_range(1, 6)), 8'($urandom_range(255)), length,
				1'($urandom_range(1)), 1'($urandom_range(1)));
			send_word(REQ_STOP, 8'($urandom()));
			play_sample(25, BYTES_RANDOM, 8, p == 1);
		end
		drain_outputs();
		send_idle_pct = 0;
		rsp_stall_pct = 0;
	endtask

	// Top start offset: address wraps past 0x7FFF, buffer overwrites, interrupt at the end
	task automatic test_address_wrap();
		drain_outputs();
		set_config(10'd3, 8'd255, 8'd4, 1'b0, 1'b1);
		send_word(REQ_STOP, 8'($urandom()));
		send_word(REQ_START, 8'($urandom()));
		send_word(REQ_START, 8'($urandom()));
		repeat (65) send_word(REQ_BYTE, 8'($urandom()));
		send_word(REQ_BYTE, 8'($urandom()));
		send_word(REQ_START, 8'($urandom()));
		send_word(REQ_STOP, 8'($urandom()));
	endtask

	// Longest sample length, then stop
	task automatic test_length_extreme();
		drain_outputs();
		set_config(10'd3, 8'd0, 8'd255, 1'b0, 1'b0);
		send_word(REQ_START, 8'($urandom()));
		send_word(REQ_TICK, 8'($urandom()));
		send_word(REQ_STOP, 8'($urandom()));
	endtask

	// Zero period wraps the counter; the largest period waits for the next reload
	task automatic test_period_extremes();
		drain_outputs();
		write_reg(REG_PERIOD, 10'd0);
		end_config();
		tick_until_bit();
		repeat (3) send_word(REQ_TICK, 8'($urandom()));
		drain_outputs();
		write_reg(REG_PERIOD, 10'd1023);
		end_config();
		repeat (2) send_word(REQ_TICK, 8'($urandom()));
	endtask

	// Randomize receiver backpressure per the current phase
	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
	end

	// Compare each returned word against the oldest prediction
	always @(posedge clk) begin : check_outputs
		out_word_t due;
		if (rsp_valid && rsp_ready) begin
			if (channel_outputs_due.size() == 0) begin
				report_mismatch("result word with nothing outstanding", 1, 0);
			end else begin
				due = channel_outputs_due.pop_front();
				if (rsp.level_out !== due.level_out)
					report_mismatch("level_out", 32'(rsp.level_out), 32'(due.level_out));
				if (rsp.fetch_request !== due.fetch_request)
					report_mismatch("fetch_request", 32'(rsp.fetch_request),
						32'(due.fetch_request));
				if (rsp.fetch_address !== due.fetch_address)
					report_mismatch("fetch_address", 32'(rsp.fetch_address),
						32'(due.fetch_address));
				if (rsp.interrupt_flag !== due.interrupt_flag)
					report_mismatch("interrupt_flag", 32'(rsp.interrupt_flag),
						32'(due.interrupt_flag));
				if (rsp.bytes_pending !== due.bytes_pending)
					report_mismatch("bytes_pending", 32'(rsp.bytes_pending),
						32'(due.bytes_pending));
			end
		end
	end

	// End the run if no word moves on any channel for too long
	initial begin : watchdog
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin
		chan             = '0;
		chan.countdown   = PERIOD_RESET;
		shadow_regs      = '0;
		shadow_regs.period_reload = PERIOD_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_level_limits();
		test_stop_playout();
		test_random_traffic();
		test_address_wrap();
		test_length_extreme();
		test_period_extremes();
		drain_outputs();
		repeat (8) @(posedge clk);
		if (channel_outputs_due.size() != 0)
			report_mismatch("result words never returned", channel_outputs_due.size(), 0);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

>>> delta_sample_channel.f
sv/dsc_pkg.sv
sv/dsc_regs.sv
sv/dsc_core.sv
sv/delta_sample_channel.sv
bench/testbench.sv
